@@ rtl/core/cansfd_pkg.sv @@
// ----------------------------------------------------------------------------
// CAN signal field decoder package
// Shared types and fixed widths for the rule table, the field extractor,
// the shared multiply-accumulate unit and the scan sequencer.
// ----------------------------------------------------------------------------
package cansfd_pkg;

  // Fixed field widths of the item interface.
  localparam int unsigned FrameIdW   = 29;
  localparam int unsigned SlotFieldW = 5;
  localparam int unsigned PayloadW   = 64;
  localparam int unsigned ScaleW     = 32;
  localparam int unsigned ValueW     = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxBytes   = 8;

  // Width of the exact product-plus-offset before saturation.
  localparam int unsigned AccW  = 96;
  // Width of one signed partial product (33 by 33 bits).
  localparam int unsigned ProdW = 66;

  // Item modes.
  localparam logic ModeLoad   = 1'b0;
  localparam logic ModeDecode = 1'b1;

  // One signal rule as it is held in the table.
  typedef struct packed {
    logic [FrameIdW-1:0] frame_id;
    logic                is_bit_field;
    logic                big_endian;
    logic [2:0]          first_byte;
    logic [3:0]          end_byte;
    logic [2:0]          first_bit;
    logic [3:0]          bit_count;
    logic [ScaleW-1:0]   gain;
    logic [ScaleW-1:0]   bias;
  } rule_t;

  // Operation of the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LO,
    MAC_HI
  } mac_op_e;

  // Scan sequencer states.
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_FETCH,
    SEQ_MATCH,
    SEQ_MUL_LO,
    SEQ_MUL_HI,
    SEQ_SUM,
    SEQ_FLUSH
  } seq_state_e;

endpackage

@@ rtl/core/cansfd_rule_table.sv @@
// ----------------------------------------------------------------------------
// Rule table
// Holds the signal rules in a memory with a registered read port, plus one
// valid flip-flop per slot that reset clears.
// ----------------------------------------------------------------------------
module cansfd_rule_table
  import cansfd_pkg::*;
#(
  parameter int unsigned RULE_SLOTS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic we_i,
  input  logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] waddr_i,
  input  rule_t wdata_i,
  input  logic re_i,
  input  logic [((RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1)-1:0] raddr_i,
  output rule_t rdata_o,
  output logic valid_o
);

  localparam int unsigned SlotW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;

  rule_t                 mem_q [RULE_SLOTS];
  rule_t                 rdata_q;
  logic [RULE_SLOTS-1:0] valid_q;

  // A slot becomes valid on its first write and stays valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  // Rule storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign valid_o = valid_q[raddr_i[SlotW-1:0]];

endmodule

@@ rtl/core/cansfd_extract.sv @@
// ----------------------------------------------------------------------------
// Field extractor
// Pulls the raw value of one rule out of the frame data: a byte range in
// either byte order with sign extension, or an unsigned bit field.
// ----------------------------------------------------------------------------
module cansfd_extract
  import cansfd_pkg::*;
#(
  parameter int unsigned FRAME_BYTES = 8
) (
  input  rule_t               rule_i,
  input  logic [PayloadW-1:0] payload_i,
  output logic [ValueW-1:0]   raw_o
);

  logic [ByteW-1:0] frame_byte [MaxBytes];
  logic [ByteW-1:0] field_byte [MaxBytes];
  logic [3:0]       span;
  logic [3:0]       src;
  logic [3:0]       top_idx;
  logic             sign;
  logic [ByteW-1:0] bit_byte;
  logic [ByteW-1:0] bit_mask;

  // Frame bytes beyond the frame length read as zero.
  always_comb begin
    for (int k = 0; k < MaxBytes; k++) begin
      frame_byte[k] = (k < FRAME_BYTES) ? payload_i[ByteW*k +: ByteW] : '0;
    end
  end

  // Byte range assembly, then sign extension from the top byte of the range.
  always_comb begin
    span = (rule_i.end_byte > {1'b0, rule_i.first_byte}) ?
           (rule_i.end_byte - {1'b0, rule_i.first_byte}) : 4'd0;
    for (int k = 0; k < MaxBytes; k++) begin
      src = rule_i.big_endian ? (rule_i.end_byte - 4'd1 - 4'(k))
                              : ({1'b0, rule_i.first_byte} + 4'(k));
      if ((4'(k) < span) && (src < 4'(MaxBytes))) begin
        field_byte[k] = frame_byte[src[2:0]];
      end else begin
        field_byte[k] = '0;
      end
    end
    top_idx = span - 4'd1;
    sign    = (span != 4'd0) && (span < 4'(MaxBytes)) &&
              field_byte[top_idx[2:0]][ByteW-1];
    for (int k = 0; k < MaxBytes; k++) begin
      if (sign && (4'(k) >= span)) begin
        field_byte[k] = '1;
      end
    end
  end

  // Bit field within one byte, kept unsigned.
  always_comb begin
    bit_byte = frame_byte[rule_i.first_byte] >> rule_i.first_bit;
    bit_mask = 8'((9'd1 << rule_i.bit_count[2:0]) - 9'd1);
    if (rule_i.bit_count < 4'(ByteW)) begin
      bit_byte = bit_byte & bit_mask;
    end
  end

  // Select the result of the rule kind.
  always_comb begin
    if (rule_i.is_bit_field) begin
      raw_o = {{(ValueW-ByteW){1'b0}}, bit_byte};
    end else begin
      for (int k = 0; k < MaxBytes; k++) begin
        raw_o[ByteW*k +: ByteW] = field_byte[k];
      end
    end
  end

endmodule

@@ rtl/core/cansfd_mac.sv @@
// ----------------------------------------------------------------------------
// Shared multiply-accumulate unit
// Forms gain * raw + bias exactly with one 33 by 33 bit signed multiplier
// used twice, then saturates the sum to a signed 64-bit value.
// ----------------------------------------------------------------------------
module cansfd_mac
  import cansfd_pkg::*;
(
  input  logic              clk_i,
  input  mac_op_e           op_i,
  input  logic [ValueW-1:0] raw_i,
  input  logic [ScaleW-1:0] gain_i,
  input  logic [ScaleW-1:0] bias_i,
  output logic [ValueW-1:0] result_o
);

  logic signed [ScaleW:0]  mul_a;
  logic signed [ScaleW:0]  mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q;
  logic signed [AccW-1:0]  sum;
  logic                    fits;

  // Low pass takes the unsigned low word, high pass the signed high word.
  always_comb begin
    mul_a = (op_i == MAC_HI) ? $signed({raw_i[ValueW-1], raw_i[ValueW-1:ScaleW]})
                             : $signed({1'b0, raw_i[ScaleW-1:0]});
    mul_b = $signed({gain_i[ScaleW-1], gain_i});
    mul_p = mul_a * mul_b;
  end

  // Partial product register and accumulator of low product plus bias.
  always_ff @(posedge clk_i) begin
    case (op_i)
      MAC_LO: begin
        prod_q <= mul_p;
      end
      MAC_HI: begin
        prod_q <= mul_p;
        acc_q  <= AccW'(prod_q) + AccW'($signed(bias_i));
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  // Add the high product weighted by 2^32 and clamp to the signed range.
  always_comb begin
    sum  = acc_q + (AccW'(prod_q) <<< ScaleW);
    fits = (sum[AccW-1:ValueW-1] == '0) || (sum[AccW-1:ValueW-1] == '1);
    if (fits) begin
      result_o = sum[ValueW-1:0];
    end else if (sum[AccW-1]) begin
      result_o = {1'b1, {(ValueW-1){1'b0}}};
    end else begin
      result_o = {1'b0, {(ValueW-1){1'b1}}};
    end
  end

endmodule

@@ rtl/core/can_signal_field_decoder_top.sv @@
// ----------------------------------------------------------------------------
// CAN signal field decoder top level
// Rule table, scan sequencer, field extractor and shared multiply-accumulate
// unit that turn a CAN frame into scaled signal values.
// ----------------------------------------------------------------------------
// Usage:
// An input item with mode 0 writes one rule into slot rule_slot_i; a slot
// beyond the table is ignored. An input item with mode 1
// carries a frame id and payload; the block then walks every rule slot in
// ascending order and sends one output item per valid rule whose id matches,
// with last_o set on the final one. A frame without matches sends nothing.
// The input stalls from acceptance of a decode item until its last output
// item sits in the output register. The walk reads every slot in SEQ_FETCH;
// a valid slot is compared in SEQ_MATCH, a match passes through SEQ_MUL_LO,
// SEQ_MUL_HI and SEQ_SUM, and SEQ_FLUSH closes the walk. The length of the
// stall is set by the single table read port and the two passes through
// the shared multiplier. One finished value waits in a holding register until
// the next match or the end of the walk decides its last flag. When
// out_stall_i is high the output item holds and the walk pauses at the
// next finished value. Reset clears all rule valid bits and the sequencer;
// no clearing pass runs.
// ----------------------------------------------------------------------------
module can_signal_field_decoder_top
  import cansfd_pkg::*;
#(
  parameter int unsigned RULE_SLOTS  = 32,
  parameter int unsigned FRAME_BYTES = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [SlotFieldW-1:0] rule_slot_i,
  input  logic [FrameIdW-1:0]   frame_id_i,
  input  logic                  is_bit_field_i,
  input  logic                  big_endian_i,
  input  logic [2:0]            first_byte_i,
  input  logic [3:0]            end_byte_i,
  input  logic [2:0]            first_bit_i,
  input  logic [3:0]            bit_count_i,
  input  logic signed [ScaleW-1:0] gain_i,
  input  logic signed [ScaleW-1:0] bias_i,
  input  logic [PayloadW-1:0]   payload_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [SlotFieldW-1:0] signal_index_o,
  output logic signed [ValueW-1:0] physical_value_o,
  output logic                  last_o
);

  localparam int unsigned SlotW = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(RULE_SLOTS - 1);

  seq_state_e state_q, state_d;

  logic [SlotW-1:0]      scan_q;
  logic [FrameIdW-1:0]   frame_id_q;
  logic [PayloadW-1:0]   payload_q;
  logic [ValueW-1:0]     raw_q;
  logic                  pend_valid_q;
  logic [SlotFieldW-1:0] pend_index_q;
  logic [ValueW-1:0]     pend_value_q;
  logic                  out_valid_q;
  logic [SlotFieldW-1:0] out_index_q;
  logic [ValueW-1:0]     out_value_q;
  logic                  out_last_q;

  logic [SlotW+SlotFieldW-1:0] slot_ext;
  logic [SlotW+SlotFieldW-1:0] scan_ext;
  logic                  slot_ok;
  rule_t                 wr_rule;
  rule_t                 rd_rule;
  logic                  rd_valid;
  logic [ValueW-1:0]     raw;
  logic [ValueW-1:0]     mac_result;
  logic                  out_free;

  logic    tbl_we;
  logic    tbl_re;
  mac_op_e mac_op;
  logic    start;
  logic    raw_ld;
  logic    pend_ld;
  logic    push;
  logic    push_last;
  logic    scan_step;

  // Slot range check and index widths.
  assign slot_ext = {{SlotW{1'b0}}, rule_slot_i};
  assign scan_ext = {{SlotFieldW{1'b0}}, scan_q};
  assign slot_ok  = slot_ext < (SlotW+SlotFieldW)'(RULE_SLOTS);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    wr_rule.frame_id     = frame_id_i;
    wr_rule.is_bit_field = is_bit_field_i;
    wr_rule.big_endian   = big_endian_i;
    wr_rule.first_byte   = first_byte_i;
    wr_rule.end_byte     = end_byte_i;
    wr_rule.first_bit    = first_bit_i;
    wr_rule.bit_count    = bit_count_i;
    wr_rule.gain         = gain_i;
    wr_rule.bias         = bias_i;
  end

  cansfd_rule_table #(
    .RULE_SLOTS(RULE_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (tbl_we),
    .waddr_i (slot_ext[SlotW-1:0]),
    .wdata_i (wr_rule),
    .re_i    (tbl_re),
    .raddr_i (scan_q),
    .rdata_o (rd_rule),
    .valid_o (rd_valid)
  );

  cansfd_extract #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_extract (
    .rule_i    (rd_rule),
    .payload_i (payload_q),
    .raw_o     (raw)
  );

  cansfd_mac u_mac (
    .clk_i    (clk_i),
    .op_i     (mac_op),
    .raw_i    (raw_q),
    .gain_i   (rd_rule.gain),
    .bias_i   (rd_rule.bias),
    .result_o (mac_result)
  );

  // Sequencer state register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SEQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and control for the walk over the rule slots.
  always_comb begin
    state_d   = state_q;
    tbl_we    = 1'b0;
    tbl_re    = 1'b0;
    mac_op    = MAC_HOLD;
    start     = 1'b0;
    raw_ld    = 1'b0;
    pend_ld   = 1'b0;
    push      = 1'b0;
    push_last = 1'b0;
    scan_step = 1'b0;
    case (state_q)
      SEQ_IDLE: begin
        if (in_valid_i) begin
          if (mode_i == ModeDecode) begin
            start   = 1'b1;
            state_d = SEQ_FETCH;
          end else begin
            tbl_we = slot_ok;
          end
        end
      end
      SEQ_FETCH: begin
        tbl_re = 1'b1;
        if (rd_valid) begin
          state_d = SEQ_MATCH;
        end else begin
          scan_step = 1'b1;
        end
      end
      SEQ_MATCH: begin
        if (rd_rule.frame_id == frame_id_q) begin
          raw_ld  = 1'b1;
          state_d = SEQ_MUL_LO;
        end else begin
          scan_step = 1'b1;
        end
      end
      SEQ_MUL_LO: begin
        mac_op  = MAC_LO;
        state_d = SEQ_MUL_HI;
      end
      SEQ_MUL_HI: begin
        mac_op  = MAC_HI;
        state_d = SEQ_SUM;
      end
      SEQ_SUM: begin
        // The held value moves on only once the next one is known.
        if (!pend_valid_q || out_free) begin
          pend_ld   = 1'b1;
          push      = pend_valid_q;
          scan_step = 1'b1;
        end
      end
      SEQ_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = SEQ_IDLE;
        end else if (out_free) begin
          push      = 1'b1;
          push_last = 1'b1;
          state_d   = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
    if (scan_step) begin
      state_d = (scan_q == LastSlot) ? SEQ_FLUSH : SEQ_FETCH;
    end
  end

  // Control registers: slot counter, holding and output valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q       <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (start) begin
        scan_q <= '0;
      end else if (scan_step && (scan_q != LastSlot)) begin
        scan_q <= scan_q + 1'b1;
      end
      if (pend_ld) begin
        pend_valid_q <= 1'b1;
      end else if (push) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Data registers of the frame, the raw value and the results.
  always_ff @(posedge clk_i) begin
    if (start) begin
      frame_id_q <= frame_id_i;
      payload_q  <= payload_i;
    end
    if (raw_ld) begin
      raw_q <= raw;
    end
    if (pend_ld) begin
      pend_index_q <= scan_ext[SlotFieldW-1:0];
      pend_value_q <= mac_result;
    end
    if (push) begin
      out_index_q <= pend_index_q;
      out_value_q <= pend_value_q;
      out_last_q  <= push_last;
    end
  end

  assign in_stall_o       = (state_q != SEQ_IDLE);
  assign out_valid_o      = out_valid_q;
  assign signal_index_o   = out_index_q;
  assign physical_value_o = out_value_q;
  assign last_o           = out_last_q;

  // The block only takes items with nothing held back from a frame.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_IDLE) |-> !pend_valid_q)
    else $error("value still held while the block is idle");

  // A rule is compared only on the cycle after its table read.
  a_match_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_MATCH) |-> $past(state_q == SEQ_FETCH))
    else $error("rule compared without a preceding table read");

  // The sum is formed only after both multiplier passes.
  a_sum_after_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_SUM) |-> ($past(state_q) == SEQ_MUL_HI || $past(state_q) == SEQ_SUM))
    else $error("sum formed without both multiplier passes");

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// CAN signal field decoder testbench
// Loads signal rules, decodes frames against them and compares every output
// item with an in-bench model of the rule table, field extraction and the
// saturated Q47.16 scaling. Both handshakes idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import cansfd_pkg::*;

  localparam int unsigned SLOTS      = 32;
  localparam int unsigned CYCLE_CAP  = 1000000;
  localparam int unsigned DRAIN_WAIT = 200;

  localparam logic signed [127:0] VALUE_MAX = 128'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [127:0] VALUE_MIN = -128'sh8000_0000_0000_0000;

  // One input item as the sender drives it.
  typedef struct {
    logic                 mode;
    logic [SlotFieldW-1:0] slot;
    logic [FrameIdW-1:0]  id;
    logic                 is_bit_field;
    logic                 big_endian;
    logic [2:0]           first_byte;
    logic [3:0]           end_byte;
    logic [2:0]           first_bit;
    logic [3:0]           bit_count;
    logic [ScaleW-1:0]    gain;
    logic [ScaleW-1:0]    bias;
    logic [PayloadW-1:0]  payload;
  } frame_item_t;

  // One decoded signal that the block should send.
  typedef struct {
    logic [SlotFieldW-1:0] index;
    logic [ValueW-1:0]     value;
    logic                  last;
  } signal_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_stall_o;
  logic                     mode_i = ModeLoad;
  logic [SlotFieldW-1:0]    rule_slot_i = '0;
  logic [FrameIdW-1:0]      frame_id_i = '0;
  logic                     is_bit_field_i = 1'b0;
  logic                     big_endian_i = 1'b0;
  logic [2:0]               first_byte_i = '0;
  logic [3:0]               end_byte_i = '0;
  logic [2:0]               first_bit_i = '0;
  logic [3:0]               bit_count_i = '0;
  logic signed [ScaleW-1:0] gain_i = '0;
  logic signed [ScaleW-1:0] bias_i = '0;
  logic [PayloadW-1:0]      payload_i = '0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic [SlotFieldW-1:0]    signal_index_o;
  logic signed [ValueW-1:0] physical_value_o;
  logic                     last_o;

  // Model state: the rule table and its valid bits.
  rule_t          rule_table [SLOTS];
  logic           rule_live  [SLOTS];
  signal_result_t pending_signals [$];

  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  int          in_gap_max = 12;
  int          out_gap_max = 12;
  int          stall_left = 0;
  logic [FrameIdW-1:0] id_pool [4];

  can_signal_field_decoder_top u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .mode_i           (mode_i),
    .rule_slot_i      (rule_slot_i),
    .frame_id_i       (frame_id_i),
    .is_bit_field_i   (is_bit_field_i),
    .big_endian_i     (big_endian_i),
    .first_byte_i     (first_byte_i),
    .end_byte_i       (end_byte_i),
    .first_bit_i      (first_bit_i),
    .bit_count_i      (bit_count_i),
    .gain_i           (gain_i),
    .bias_i           (bias_i),
    .payload_i        (payload_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .signal_index_o   (signal_index_o),
    .physical_value_o (physical_value_o),
    .last_o           (last_o)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("%0t: run exceeded %0d cycles", $time, CYCLE_CAP);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Reads one data byte; bytes past the frame read as zero.
  function automatic logic [63:0] data_byte(logic [PayloadW-1:0] data, int idx);
    if (idx >= MaxBytes) return 64'd0;
    return {56'd0, data[8*idx +: 8]};
  endfunction

  // Extracts the raw field value of one rule from the frame data.
  function automatic logic [63:0] field_raw(rule_t r, logic [PayloadW-1:0] data);
    logic [63:0] v;
    int fb;
    int eb;
    int n;
    int sh;
    v  = 64'd0;
    fb = int'(r.first_byte);
    eb = int'(r.end_byte);
    if (r.is_bit_field) begin
      v = data_byte(data, fb) >> r.first_bit;
      if (r.bit_count < 4'd8) v &= (64'd1 << r.bit_count) - 64'd1;
      return v;
    end
    if (eb <= fb) return 64'd0;
    n = eb - fb;
    for (int j = fb; j < eb; j++) begin
      sh = r.big_endian ? 8 * (eb - 1 - j) : 8 * (j - fb);
      if (sh < 64) v |= data_byte(data, j) << sh;
    end
    // Narrow fields are signed and get extended from their top bit.
    if (n < 8 && v[8*n-1]) v |= ~((64'd1 << (8 * n)) - 64'd1);
    return v;
  endfunction

  // Exact gain * raw + bias, saturated to the signed 64-bit range.
  function automatic logic [ValueW-1:0] scaled_value(logic signed [31:0] g,
                                                     logic signed [31:0] b,
                                                     logic [63:0] raw);
    logic signed [127:0] gx;
    logic signed [127:0] rx;
    logic signed [127:0] bx;
    logic signed [127:0] acc;
    gx  = 128'(g);
    rx  = 128'($signed(raw));
    bx  = 128'(b);
    acc = gx * rx + bx;
    if (acc > VALUE_MAX) acc = VALUE_MAX;
    if (acc < VALUE_MIN) acc = VALUE_MIN;
    return acc[63:0];
  endfunction

  // Applies one accepted item to the model and queues its signals.
  function automatic void predict_signals(frame_item_t it);
    signal_result_t res;
    int hits;
    int k;
    hits = 0;
    k    = 0;
    if (it.mode == ModeLoad) begin
      rule_table[it.slot] = '{frame_id: it.id, is_bit_field: it.is_bit_field,
                              big_endian: it.big_endian, first_byte: it.first_byte,
                              end_byte: it.end_byte, first_bit: it.first_bit,
                              bit_count: it.bit_count, gain: it.gain, bias: it.bias};
      rule_live[it.slot] = 1'b1;
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (rule_live[i] && rule_table[i].frame_id == it.id) hits++;
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (rule_live[i] && rule_table[i].frame_id == it.id) begin
        k++;
        res.index = i[SlotFieldW-1:0];
        res.value = scaled_value($signed(rule_table[i].gain), $signed(rule_table[i].bias),
                                 field_raw(rule_table[i], it.payload));
        res.last  = (k == hits);
        pending_signals.insert(pending_signals.size(), res);
      end
    end
  endfunction

  // Sends one item after a random gap and updates the model on acceptance.
  task automatic send_item(frame_item_t it);
    int gap;
    gap = $urandom_range(in_gap_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mode_i         <= it.mode;
    rule_slot_i    <= it.slot;
    frame_id_i     <= it.id;
    is_bit_field_i <= it.is_bit_field;
    big_endian_i   <= it.big_endian;
    first_byte_i   <= it.first_byte;
    end_byte_i     <= it.end_byte;
    first_bit_i    <= it.first_bit;
    bit_count_i    <= it.bit_count;
    gain_i         <= it.gain;
    bias_i         <= it.bias;
    payload_i      <= it.payload;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_signals(it);
  endtask

  task automatic load_rule(int slot, logic [FrameIdW-1:0] id, logic bitf, logic big,
                           int fb, int eb, int fbit, int cnt,
                           logic [31:0] gain, logic [31:0] bias);
    frame_item_t it;
    it = '{mode: ModeLoad, slot: slot[SlotFieldW-1:0], id: id, is_bit_field: bitf,
           big_endian: big, first_byte: fb[2:0], end_byte: eb[3:0], first_bit: fbit[2:0],
           bit_count: cnt[3:0], gain: gain, bias: bias,
           payload: {$urandom(), $urandom()}};
    send_item(it);
  endtask

  task automatic decode_frame(logic [FrameIdW-1:0] id, logic [PayloadW-1:0] data);
    frame_item_t it;
    it = '{mode: ModeDecode, slot: 5'($urandom_range(31, 0)), id: id,
           is_bit_field: 1'($urandom_range(1, 0)), big_endian: 1'($urandom_range(1, 0)),
           first_byte: 3'($urandom_range(7, 0)), end_byte: 4'($urandom_range(8, 0)),
           first_bit: 3'($urandom_range(7, 0)), bit_count: 4'($urandom_range(8, 0)),
           gain: $urandom(), bias: $urandom(), payload: data};
    send_item(it);
  endtask

  // Receiver: checks each accepted output item and draws the next stall.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_signals.size() == 0) begin
        $display("%0t: unexpected signal, got index %0d value %0d last %0b",
                 $time, signal_index_o, physical_value_o, last_o);
        fail_count++;
      end else begin
        if (signal_index_o !== pending_signals[0].index) begin
          $display("%0t: signal_index expected %0d, got %0d",
                   $time, pending_signals[0].index, signal_index_o);
          fail_count++;
        end
        if (physical_value_o !== pending_signals[0].value) begin
          $display("%0t: physical_value expected %0d, got %0d", $time,
                   $signed(pending_signals[0].value), physical_value_o);
          fail_count++;
        end
        if (last_o !== pending_signals[0].last) begin
          $display("%0t: last expected %0b, got %0b",
                   $time, pending_signals[0].last, last_o);
          fail_count++;
        end
        void'(pending_signals.pop_front());
      end
      stall_left = $urandom_range(out_gap_max, 0);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left > 0);
  end

  // A frame decoded against an empty table yields nothing.
  task automatic test_empty_table();
    decode_frame(29'h0, '1);
    decode_frame(29'h1FFF_FFFF, 64'h0123_4567_89AB_CDEF);
  endtask

  // Byte and bit fields at their extremes, mostly sharing the widest id.
  task automatic test_field_extremes();
    logic [FrameIdW-1:0] top_id;
    top_id = 29'h1FFF_FFFF;
    // Whole frame, little and big endian; big endian at the largest scale and offset.
    load_rule(0, top_id, 1'b0, 1'b0, 0, 8, 0, 0, 32'h0001_0000, 32'h0);
    load_rule(31, top_id, 1'b0, 1'b1, 0, 8, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    // Bit field in the last byte at the top bit, with a count that keeps all bits.
    load_rule(5, top_id, 1'b1, 1'b0, 7, 0, 7, 8, 32'h8000_0000, 32'h8000_0000);
    // Zero bit count and a wide count on a shifted byte.
    load_rule(6, top_id, 1'b1, 1'b1, 3, 8, 0, 0, 32'hFFFF_FFFF, 32'h0001_2345);
    load_rule(12, top_id, 1'b1, 1'b0, 2, 1, 3, 15, 32'h0000_8000, 32'hFFFF_0000);
    // Empty byte range, reversed and equal ends.
    load_rule(7, top_id, 1'b0, 1'b0, 5, 3, 0, 0, 32'h0001_0000, 32'hFFFF_FFFF);
    load_rule(10, top_id, 1'b0, 1'b1, 2, 2, 0, 0, 32'h0001_0000, 32'h0000_0001);
    // Narrow signed fields that need sign extension.
    load_rule(8, top_id, 1'b0, 1'b1, 1, 4, 0, 0, 32'h0001_0000, 32'h0);
    load_rule(9, top_id, 1'b0, 1'b0, 7, 8, 0, 0, 32'hFFFF_0000, 32'h0);
    load_rule(20, top_id, 1'b0, 1'b1, 1, 8, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    decode_frame(top_id, 64'h0);
    decode_frame(top_id, '1);
    decode_frame(top_id, 64'h8080_8080_8080_8080);
    decode_frame(top_id, 64'h0123_4567_89AB_CDEF);
    decode_frame(top_id, 64'h7F7F_7F7F_7F7F_7F7F);
    // A different id matches nothing, then a rule is moved to id zero.
    decode_frame(29'h0ABC_DEF0, '1);
    load_rule(31, 29'h0, 1'b0, 1'b0, 4, 8, 0, 0, 32'h0002_0000, 32'h8000_0000);
    decode_frame(29'h0, 64'hFFFF_FFFF_0000_0000);
    decode_frame(top_id, 64'h8000_0000_0000_0001);
  endtask

  // Random rule layout and scaling, biased toward sensible byte ranges.
  task automatic load_random_rule(int slot, logic [FrameIdW-1:0] id);
    logic [31:0] gain;
    int fb;
    int eb;
    fb = $urandom_range(7, 0);
    eb = ($urandom_range(4, 0) != 0) ? $urandom_range(8, fb + 1) : $urandom_range(8, 0);
    case ($urandom_range(3, 0))
      0: gain = $urandom();
      1: gain = $urandom_range(32'h40000, 0) * (($urandom_range(1, 0) != 0) ? -1 : 1);
      2: gain = ($urandom_range(1, 0) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: gain = 32'h0001_0000;
    endcase
    load_rule(slot, id, 1'($urandom_range(1, 0)), 1'($urandom_range(1, 0)), fb, eb,
              $urandom_range(7, 0), $urandom_range(8, 0), gain, $urandom());
  endtask

  // Mixed loads and decodes over a small id pool, in chunks with and without idling.
  task automatic test_random_traffic(int count);
    logic [FrameIdW-1:0] id;
    for (int p = 0; p < 4; p++) id_pool[p] = FrameIdW'($urandom());
    id_pool[0] = 29'h1FFF_FFFF;
    for (int n = 0; n < count; n++) begin
      if (n % 50 == 0) begin
        in_gap_max  = ((n / 50) % 3 == 1) ? 0 : 12;
        out_gap_max = ((n / 50) % 3 == 2) ? 0 : 12;
      end
      id = ($urandom_range(9, 0) != 0) ? id_pool[$urandom_range(3, 0)]
                                       : FrameIdW'($urandom());
      if ($urandom_range(9, 0) < 4) begin
        load_random_rule($urandom_range(31, 0), id);
      end else begin
        decode_frame(id, {$urandom(), $urandom()});
      end
    end
  endtask

  // Every slot holds the same id, so each frame yields a full table of signals.
  task automatic test_full_table();
    logic [FrameIdW-1:0] id;
    id = FrameIdW'($urandom());
    in_gap_max  = 12;
    out_gap_max = 12;
    for (int s = 0; s < SLOTS; s++) load_random_rule(s, id);
    decode_frame(id, {$urandom(), $urandom()});
    out_gap_max = 0;
    decode_frame(id, '1);
    decode_frame(id, {$urandom(), $urandom()});
  endtask

  // Waits for all outstanding signals, then a drain wait, and counts a failure if any remain.
  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (pending_signals.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (pending_signals.size() != 0) fail_count++;
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) rule_live[i] = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_table();
    test_field_extremes();
    test_random_traffic(255);
    test_full_table();
    finish_run();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
